FILE: hdl/frac_add_pkg.sv
// ----------------------------------------------------------------------------
// frac_add_pkg
// Shared types, constants and a sign-magnitude helper for the fraction adder.
// ----------------------------------------------------------------------------
package frac_add_pkg;

	// Width of the exact intermediate magnitudes and of the divider datapath.
	localparam int DIV_W = 64;
	// Step counter width of the divider (one quotient bit per step).
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Sign and magnitude of an exact intermediate value.
	typedef struct packed {
		logic             neg;
		logic [DIV_W-1:0] mag;
	} sm_t;

	// Sign-magnitude add; a zero result is always positive.
	function automatic sm_t sm_add(sm_t x, sm_t y);
		sm_t r;
		if (x.neg == y.neg) begin
			r.mag = x.mag + y.mag;
			r.neg = x.neg;
		end else if (x.mag >= y.mag) begin
			r.mag = x.mag - y.mag;
			r.neg = x.neg;
		end else begin
			r.mag = y.mag - x.mag;
			r.neg = y.neg;
		end
		if (r.mag == '0) begin
			r.neg = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: hdl/frac_add_cell.sv
// ----------------------------------------------------------------------------
// frac_add_cell
// One bit slice of the shift-subtract divider: a remainder bit, a dividend
// or quotient bit, and one stage of the ripple borrow chain.
// ----------------------------------------------------------------------------
module frac_add_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic load,      // start a new division
	input  logic step,      // perform one shift-subtract step
	input  logic x_init,    // dividend bit loaded at start
	input  logic r_in,      // remainder bit shifted in from the lower neighbor
	input  logic x_in,      // dividend/quotient bit shifted in from the lower neighbor
	input  logic y,         // divisor bit
	input  logic b_in,      // borrow from the lower neighbor
	input  logic keep,      // trial subtraction failed, keep the shifted bit
	output logic b_out,     // borrow to the upper neighbor
	output logic r_q,
	output logic x_q
);

	logic diff;

	assign diff  = r_in ^ y ^ b_in;
	assign b_out = (~r_in & y) | (~r_in & b_in) | (y & b_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= 1'b0;
			x_q <= 1'b0;
		end else if (load) begin
			r_q <= 1'b0;
			x_q <= x_init;
		end else if (step) begin
			r_q <= keep ? r_in : diff;
			x_q <= x_in;
		end
	end

endmodule

FILE: hdl/frac_add_div.sv
// ----------------------------------------------------------------------------
// frac_add_div
// Unsigned restoring divider built from a row of bit cells; one quotient
// bit per cycle, quotient and remainder valid when done pulses.
// ----------------------------------------------------------------------------
module frac_add_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [frac_add_pkg::DIV_W-1:0] dividend,
	input  logic [frac_add_pkg::DIV_W-1:0] divisor,
	output logic                           done,
	output logic [frac_add_pkg::DIV_W-1:0] quot,
	output logic [frac_add_pkg::DIV_W-1:0] rem
);

	import frac_add_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     y_q;
	logic [DIV_W:0]       borrow;
	logic [DIV_W-1:0]     r_bits;
	logic [DIV_W-1:0]     x_bits;
	logic                 keep;

	assign borrow[0] = 1'b0;
	// A borrow out of the top cell means the shifted remainder is below the divisor,
	// unless the shift carried a one out of the top remainder bit.
	assign keep = borrow[DIV_W] & ~r_bits[DIV_W-1];

	for (genvar i = 0; i < DIV_W; i++) begin : g_cell
		logic r_src;
		logic x_src;
		if (i == 0) begin : g_low
			assign r_src = x_bits[DIV_W-1];
			assign x_src = ~keep;
		end else begin : g_up
			assign r_src = r_bits[i-1];
			assign x_src = x_bits[i-1];
		end
		frac_add_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (start),
			.step   (busy_q),
			.x_init (dividend[i]),
			.r_in   (r_src),
			.x_in   (x_src),
			.y      (y_q[i]),
			.b_in   (borrow[i]),
			.keep   (keep),
			.b_out  (borrow[i+1]),
			.r_q    (r_bits[i]),
			.x_q    (x_bits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q <= divisor;
		end
	end

	assign done = done_q;
	assign quot = x_bits;
	assign rem  = r_bits;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == DIV_CNT_W'(DIV_W - 1)) |=> done_q)
		else $error("divider missed its done pulse");

endmodule

FILE: hdl/fraction_add_reduce_top.sv
// ----------------------------------------------------------------------------
// fraction_add_reduce_top
// Adds two signed fractions and reduces the sum to lowest terms.
// ----------------------------------------------------------------------------
// The block takes one word holding a/b and c/d and returns one word holding
// the reduced sum. It works on one word at a time: after an input word is
// accepted, the operands are decoded and, unless a zero numerator or equal
// denominators allow a shortcut, cross-multiplied on a single multiplier;
// then a divider made of a row of 64 bit cells runs the Euclidean GCD and
// the two final divisions. A zero denominator skips the arithmetic and
// finishes with 0/0 and the invalid flag. A new input word is taken while a
// finished result still waits in the output register.
module fraction_add_reduce_top #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// num_a, den_a, num_b, den_b (OPERAND_WIDTH bits each), zero padded
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]          s_tdata,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// sum_num [63:0], sum_den [127:64]
	output logic [2*frac_add_pkg::DIV_W-1:0]              m_tdata,
	// invalid [0], overflow [1]
	output logic [1:0]                                    m_tuser
);

	import frac_add_pkg::*;

	localparam int W   = OPERAND_WIDTH;
	localparam int P_W = 2 * W;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CASE      = 4'd1;
	localparam logic [3:0] S_MUL1      = 4'd2;
	localparam logic [3:0] S_MUL2      = 4'd3;
	localparam logic [3:0] S_MUL3      = 4'd4;
	localparam logic [3:0] S_ADD       = 4'd5;
	localparam logic [3:0] S_SIGN      = 4'd6;
	localparam logic [3:0] S_GCD       = 4'd7;
	localparam logic [3:0] S_GCD_WAIT  = 4'd8;
	localparam logic [3:0] S_DIVN      = 4'd9;
	localparam logic [3:0] S_DIVN_WAIT = 4'd10;
	localparam logic [3:0] S_DIVM      = 4'd11;
	localparam logic [3:0] S_DIVM_WAIT = 4'd12;
	localparam logic [3:0] S_OUT       = 4'd13;

	logic [3:0] state_q;

	// Operands in sign-magnitude form: 0 = a, 1 = b, 2 = c, 3 = d.
	logic         in_neg [4];
	logic [W-1:0] in_mag [4];
	logic         op_neg_q [4];
	logic [W-1:0] op_mag_q [4];
	sm_t          op_ext [4];

	sm_t              n_q;
	sm_t              m_q;
	sm_t              p1_q;
	logic [DIV_W-1:0] ga_q;
	logic [DIV_W-1:0] gb_q;
	logic             invalid_q;

	logic             m_tvalid_q;
	logic [DIV_W-1:0] out_num_q;
	logic [DIV_W-1:0] out_den_q;
	logic             out_inv_q;
	logic             out_ovf_q;

	logic [W-1:0]     mul_x;
	logic [W-1:0]     mul_y;
	logic             mul_neg;
	logic [P_W-1:0]   prod;
	sm_t              prod_sm;

	logic             div_start;
	logic [DIV_W-1:0] div_x;
	logic [DIV_W-1:0] div_y;
	logic             div_done;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] div_r;

	logic             out_free;
	logic             ovf;

	for (genvar k = 0; k < 4; k++) begin : g_dec
		logic [W-1:0] f;
		assign f         = s_tdata[k*W +: W];
		assign in_neg[k] = f[W-1];
		assign in_mag[k] = f[W-1] ? (~f + 1'b1) : f;
		assign op_ext[k] = '{neg: op_neg_q[k], mag: DIV_W'(op_mag_q[k])};
	end

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// One multiplier, shared over the three cross products.
	always_comb begin
		unique case (state_q)
			S_MUL1: begin
				mul_x   = op_mag_q[0];
				mul_y   = op_mag_q[3];
				mul_neg = op_neg_q[0] ^ op_neg_q[3];
			end
			S_MUL2: begin
				mul_x   = op_mag_q[1];
				mul_y   = op_mag_q[2];
				mul_neg = op_neg_q[1] ^ op_neg_q[2];
			end
			default: begin
				mul_x   = op_mag_q[1];
				mul_y   = op_mag_q[3];
				mul_neg = op_neg_q[1] ^ op_neg_q[3];
			end
		endcase
	end

	assign prod        = mul_x * mul_y;
	assign prod_sm.mag = DIV_W'(prod);
	assign prod_sm.neg = (prod != '0) && mul_neg;

	// Divider launches: Euclid steps, then the numerator and denominator by the GCD.
	always_comb begin
		div_start = 1'b0;
		div_x     = ga_q;
		div_y     = gb_q;
		unique case (state_q)
			S_GCD: begin
				div_start = (gb_q != '0);
			end
			S_DIVN: begin
				div_start = 1'b1;
				div_x     = n_q.mag;
				div_y     = ga_q;
			end
			S_DIVM: begin
				div_start = 1'b1;
				div_x     = m_q.mag;
				div_y     = ga_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	frac_add_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_x),
		.divisor  (div_y),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	// Only a positive 2^63 can fall outside the signed range.
	assign ovf = n_q.neg ? (n_q.mag[DIV_W-1] && (n_q.mag[DIV_W-2:0] != '0))
	                     : n_q.mag[DIV_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output register is loaded when free and drained when taken.
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CASE;
					end
				end
				S_CASE: begin
					priority if (op_mag_q[1] == '0 || op_mag_q[3] == '0) begin
						state_q <= S_OUT;
					end else if (op_mag_q[0] == '0 || op_mag_q[2] == '0 ||
					             (op_neg_q[1] == op_neg_q[3] &&
					              op_mag_q[1] == op_mag_q[3])) begin
						state_q <= S_SIGN;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1:      state_q <= S_MUL2;
				S_MUL2:      state_q <= S_MUL3;
				S_MUL3:      state_q <= S_ADD;
				S_ADD:       state_q <= S_SIGN;
				S_SIGN:      state_q <= S_GCD;
				S_GCD: begin
					state_q <= (gb_q == '0) ? S_DIVN : S_GCD_WAIT;
				end
				S_GCD_WAIT: begin
					if (div_done) begin
						state_q <= S_GCD;
					end
				end
				S_DIVN:      state_q <= S_DIVN_WAIT;
				S_DIVN_WAIT: begin
					if (div_done) begin
						state_q <= S_DIVM;
					end
				end
				S_DIVM:      state_q <= S_DIVM_WAIT;
				S_DIVM_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					for (int k = 0; k < 4; k++) begin
						op_neg_q[k] <= in_neg[k];
						op_mag_q[k] <= in_mag[k];
					end
				end
			end
			S_CASE: begin
				invalid_q <= (op_mag_q[1] == '0 || op_mag_q[3] == '0);
				priority if (op_mag_q[1] == '0 || op_mag_q[3] == '0) begin
					n_q       <= '0;
					m_q       <= '0;
				end else if (op_mag_q[0] == '0) begin
					n_q <= op_ext[2];
					m_q <= op_ext[3];
				end else if (op_mag_q[2] == '0) begin
					n_q <= op_ext[0];
					m_q <= op_ext[1];
				end else if (op_neg_q[1] == op_neg_q[3] && op_mag_q[1] == op_mag_q[3]) begin
					n_q <= sm_add(op_ext[0], op_ext[2]);
					m_q <= op_ext[1];
				end else begin
					n_q <= n_q;
				end
			end
			S_MUL1: p1_q <= prod_sm;
			S_MUL2: n_q  <= prod_sm;
			S_MUL3: m_q  <= prod_sm;
			S_ADD:  n_q  <= sm_add(p1_q, n_q);
			S_SIGN: begin
				// A fraction with both parts negative is made positive.
				if (n_q.neg && m_q.neg) begin
					n_q.neg <= 1'b0;
					m_q.neg <= 1'b0;
				end
				ga_q <= n_q.mag;
				gb_q <= m_q.mag;
			end
			S_GCD_WAIT: begin
				if (div_done) begin
					ga_q <= gb_q;
					gb_q <= div_r;
				end
			end
			S_DIVN_WAIT: begin
				if (div_done) begin
					n_q.mag <= div_q;
				end
			end
			S_DIVM_WAIT: begin
				if (div_done) begin
					m_q.mag <= div_q;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_num_q <= n_q.neg ? (~n_q.mag + 1'b1) : n_q.mag;
					out_den_q <= m_q.neg ? (~m_q.mag + 1'b1) : m_q.mag;
					out_inv_q <= invalid_q;
					out_ovf_q <= !invalid_q && ovf;
				end
			end
			default: begin
				p1_q <= p1_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_den_q, out_num_q};
	assign m_tuser  = {out_ovf_q, out_inv_q};

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_inv_q) |-> (out_num_q == '0 && out_den_q == '0 && !out_ovf_q))
		else $error("invalid result with nonzero fields");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("input taken while busy");
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVN) |-> (ga_q != '0)) else $error("zero GCD reached division");

endmodule
